// File: hw/rtl/cpq_pkg.sv
`default_nettype none
package cpq_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = SLOT_W + 1;
   localparam int RING_BYTES  = 256;
   localparam int RING_AW     = $clog2(RING_BYTES);
   localparam int LEN_W       = RING_AW + 1;
   localparam logic [7:0] NAME_MAX_BYTES = 8'd255;

   // operation codes, OP_NOP is the internal class for unused codes
   localparam logic [2:0] OP_PUSH  = 3'd0;
   localparam logic [2:0] OP_POP   = 3'd1;
   localparam logic [2:0] OP_FLUSH = 3'd2;
   localparam logic [2:0] OP_CHECK = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;
   localparam logic [2:0] OP_NOP   = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_POOL_ERR = 2'd1;
   localparam logic [1:0] ST_PENDING  = 2'd2;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] data;
      logic       last;
      logic [7:0] name_len;
      logic [7:0] offset;
   } item_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             match;
      logic [7:0]       start;
      logic [LEN_W-1:0] length;
      logic [7:0]       prefix;
      logic [7:0]       rdata;
      logic [COUNT_W-1:0] count;
      logic             empty;
      logic             full;
   } result_type;

endpackage
`default_nettype wire

// File: hw/rtl/cpq_front.sv
`default_nettype none
module cpq_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_operation,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_last_byte,
   input  wire logic [7:0]        req_name_length,
   input  wire logic [7:0]        req_read_offset,
   output logic                   item_valid,
   input  wire logic              item_take,
   output cpq_pkg::item_type      item
);
   import cpq_pkg::*;

   item_type   buf_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   item_type   cls;

   // unused operation codes fold into one no-op class
   always_comb begin
      cls.op       = (req_operation > OP_READ) ? OP_NOP : req_operation;
      cls.data     = req_data_byte;
      cls.last     = req_last_byte;
      cls.name_len = req_name_length;
      cls.offset   = req_read_offset;
   end

   assign req_stall  = cnt_ff[1];
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = buf_ff[rd_ptr_ff];
   assign push       = req_valid && !req_stall;
   assign pop        = item_valid && item_take;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= cls;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/cpq_exec.sv
`default_nettype none
module cpq_exec (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   output logic                   item_take,
   input  wire cpq_pkg::item_type item,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cpq_pkg::result_type    rsp
);
   import cpq_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_RING_RD = 3'd1;
   localparam logic [2:0] S_CHK_CMP = 3'd2;
   localparam logic [2:0] S_CHK_END = 3'd3;
   localparam logic [2:0] S_OUT     = 3'd4;

   logic [2:0] state_ff, state_in;

   logic [7:0] ring_mem [RING_BYTES];
   logic [7:0] ring_rdata_ff;
   logic               ring_we;
   logic [RING_AW-1:0] ring_waddr, ring_raddr;

   logic [7:0]       slot_start [QUEUE_DEPTH];
   logic [LEN_W-1:0] slot_len   [QUEUE_DEPTH];
   logic [7:0]       slot_pfx   [QUEUE_DEPTH];
   logic             slot_we;

   logic [RING_AW-1:0] wp_ff, wp_in;
   logic [LEN_W-1:0]   used_ff, used_in;
   logic [LEN_W-1:0]   pend_ff, pend_in;
   logic               ovf_ff, ovf_in;
   logic [SLOT_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         pos_ff, pos_in;
   logic [QUEUE_DEPTH-1:0] still_ff, still_in;
   logic [COUNT_W-1:0] k_ff, k_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   item_type           cur_ff, cur_in;
   result_type         res_ff, res_in;
   result_type         rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               fin;
   logic [LEN_W:0]     ring_sum;
   logic [LEN_W-1:0]   pend_new, pop_len;
   logic [7:0]         pos_new;
   logic [SLOT_W-1:0]  next_idx, q_off;
   logic               mismatch, any_match;

   assign item_take = (state_ff == S_IDLE) && item_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      used_in    = used_ff;
      pend_in    = pend_ff;
      ovf_in     = ovf_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      still_in   = still_ff;
      k_in       = k_ff;
      idx_in     = idx_ff;
      cur_in     = cur_ff;
      res_in     = res_ff;
      ring_we    = 1'b0;
      ring_waddr = RING_AW'(wp_ff + pend_ff[RING_AW-1:0]);
      ring_raddr = item.offset[RING_AW-1:0];
      slot_we    = 1'b0;
      fin        = 1'b0;
      ring_sum   = {1'b0, used_ff} + {1'b0, pend_ff};
      pend_new   = pend_ff;
      pop_len    = (slot_len[head_ff] > used_ff) ? used_ff : slot_len[head_ff];
      pos_new    = (pos_ff < NAME_MAX_BYTES) ? pos_ff + 8'd1 : pos_ff;
      next_idx   = idx_ff + SLOT_W'(1);
      mismatch   = 1'b0;
      any_match  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               cur_in = item;
               res_in = '0;
               if (item.op != OP_CHECK) begin
                  still_in = '1;
                  pos_in   = 8'd0;
               end
               unique case (item.op)
                  OP_PUSH: begin
                     fin = 1'b1;
                     if (ring_sum < (LEN_W + 1)'(RING_BYTES)) begin
                        ring_we  = 1'b1;
                        pend_new = pend_ff + LEN_W'(1);
                     end
                     pend_in = pend_new;
                     ovf_in  = ovf_ff || !ring_we;
                     if (!item.last) begin
                        res_in.status = ST_PENDING;
                     end else begin
                        if (ovf_in || count_ff == COUNT_W'(QUEUE_DEPTH)) begin
                           res_in.status = ST_POOL_ERR;
                        end else begin
                           slot_we       = 1'b1;
                           res_in.start  = 8'(wp_ff);
                           res_in.length = pend_new;
                           wp_in         = RING_AW'(wp_ff + pend_new[RING_AW-1:0]);
                           used_in       = used_ff + pend_new;
                           tail_in       = tail_ff + SLOT_W'(1);
                           count_in      = count_ff + COUNT_W'(1);
                        end
                        pend_in = '0;
                        ovf_in  = 1'b0;
                     end
                  end
                  OP_POP: begin
                     fin = 1'b1;
                     if (count_ff == '0) begin
                        res_in.status = ST_POOL_ERR;
                     end else begin
                        res_in.start  = slot_start[head_ff];
                        res_in.length = slot_len[head_ff];
                        res_in.prefix = slot_pfx[head_ff];
                        used_in       = used_ff - pop_len;
                        head_in       = head_ff + SLOT_W'(1);
                        count_in      = count_ff - COUNT_W'(1);
                     end
                  end
                  OP_FLUSH: begin
                     fin      = 1'b1;
                     wp_in    = '0;
                     used_in  = '0;
                     pend_in  = '0;
                     ovf_in   = 1'b0;
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end
                  OP_READ: begin
                     state_in = S_RING_RD;
                  end
                  OP_CHECK: begin
                     k_in   = '0;
                     idx_in = head_ff;
                     ring_raddr = RING_AW'(slot_start[head_ff] + pos_ff);
                     if (pos_ff < NAME_MAX_BYTES && count_ff != '0) begin
                        state_in = S_CHK_CMP;
                     end else begin
                        state_in = S_CHK_END;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         S_RING_RD: begin
            res_in.rdata = ring_rdata_ff;
            fin          = 1'b1;
         end
         S_CHK_CMP: begin
            mismatch = (pos_ff >= slot_pfx[idx_ff]) ||
                       ({1'b0, pos_ff} >= slot_len[idx_ff]) ||
                       (ring_rdata_ff != cur_ff.data);
            if (mismatch) begin
               still_in[idx_ff] = 1'b0;
            end
            k_in       = k_ff + COUNT_W'(1);
            idx_in     = next_idx;
            ring_raddr = RING_AW'(slot_start[next_idx] + pos_ff);
            if (k_in == count_ff) begin
               state_in = S_CHK_END;
            end
         end
         S_CHK_END: begin
            fin = 1'b1;
            if (!cur_ff.last) begin
               res_in.status = ST_PENDING;
               pos_in        = pos_new;
            end else begin
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  q_off = SLOT_W'(i) - head_ff;
                  if ({1'b0, q_off} < count_ff && still_ff[i] &&
                      slot_pfx[i] != 8'd0 && slot_pfx[i] == pos_new) begin
                     any_match = 1'b1;
                  end
               end
               res_in.match = any_match;
               pos_in       = 8'd0;
               still_in     = '1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      q_off = '0;
      if (fin) begin
         state_in     = S_OUT;
         res_in.count = count_in;
         res_in.empty = (count_in == '0);
         res_in.full  = (count_in == COUNT_W'(QUEUE_DEPTH));
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= item.data;
      end
      ring_rdata_ff <= ring_mem[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_start[tail_ff] <= 8'(wp_ff);
         slot_len[tail_ff]   <= pend_new;
         slot_pfx[tail_ff]   <= item.name_len;
      end
      cur_ff <= cur_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      k_ff   <= k_in;
      idx_ff <= idx_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         used_ff      <= '0;
         pend_ff      <= '0;
         ovf_ff       <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         still_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         ovf_ff       <= ovf_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         still_ff     <= still_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/command_packet_queue.sv
// command packet queue: command bytes go into a 256-byte ring and each
// committed command gets a descriptor (start, length, name-prefix length)
// in an 8-slot fifo. a two-entry request queue in front of the executor
// still takes up to two requests while a response waits on rsp_stall.
// push, pop, flush and no-op go straight to the output state, a ring read
// passes one registered ring read port first, a check byte walks the single
// ring read port across the queued descriptors and then an end state (no
// walk when the queue is empty or 255 name bytes were already compared).
// no clearing pass after reset.
`default_nettype none
module command_packet_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_operation,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   input  wire logic [7:0]  req_name_length,
   input  wire logic [7:0]  req_read_offset,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic             rsp_match,
   output logic [7:0]       rsp_cmd_base,
   output logic [8:0]       rsp_cmd_length,
   output logic [7:0]       rsp_prefix_length,
   output logic [7:0]       rsp_read_data,
   output logic [3:0]       rsp_entry_count,
   output logic             rsp_is_empty,
   output logic             rsp_is_full
);
   import cpq_pkg::*;

   // front to back item transfer
   logic       item_valid;
   logic       item_take;
   item_type   item;
   result_type rsp;

   // front: classify and buffer requests
   cpq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .req_name_length (req_name_length),
      .req_read_offset (req_read_offset),
      .item_valid      (item_valid),
      .item_take       (item_take),
      .item            (item)
   );

   // back: ring, descriptor fifo, name check walk, response register
   cpq_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   // unpack response fields onto ports
   assign rsp_status        = rsp.status;
   assign rsp_match         = rsp.match;
   assign rsp_cmd_base      = rsp.start;
   assign rsp_cmd_length    = rsp.length;
   assign rsp_prefix_length = rsp.prefix;
   assign rsp_read_data     = rsp.rdata;
   assign rsp_entry_count   = rsp.count;
   assign rsp_is_empty      = rsp.empty;
   assign rsp_is_full       = rsp.full;

endmodule
`default_nettype wire

// File: sim/tb_command_packet_queue.sv
`timescale 1ns / 1ps
module tb_command_packet_queue;
   import cpq_pkg::*;

   // unused operation codes besides the one the package names
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_operation;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic [7:0] req_name_length;
   logic [7:0] req_read_offset;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic       rsp_match;
   logic [7:0] rsp_cmd_base;
   logic [8:0] rsp_cmd_length;
   logic [7:0] rsp_prefix_length;
   logic [7:0] rsp_read_data;
   logic [3:0] rsp_entry_count;
   logic       rsp_is_empty;
   logic       rsp_is_full;

   command_packet_queue dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the queue state
   logic [7:0] ring_mem [RING_BYTES];
   bit         ring_written [RING_BYTES];
   bit         any_written;
   int         wr_pos, rd_pos, ring_fill, pend_len;
   bit         pend_ovf;
   int         desc_start [QUEUE_DEPTH];
   int         desc_len [QUEUE_DEPTH];
   int         desc_prefix [QUEUE_DEPTH];
   int         desc_head, desc_tail, desc_count;
   int         name_pos;
   bit         name_alive [QUEUE_DEPTH];

   result_type expected_rsp [$];
   int         fail_count;
   int         sent_count;
   int         rsp_count;
   int         match_count;
   int         tx_idle_pct;
   int         rx_idle_pct;

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic void restart_name_compare();
      name_pos = 0;
      for (int i = 0; i < QUEUE_DEPTH; i++) name_alive[i] = 1'b1;
   endfunction

   function automatic void clear_shadow();
      wr_pos = 0; rd_pos = 0; ring_fill = 0; pend_len = 0; pend_ovf = 0;
      desc_head = 0; desc_tail = 0; desc_count = 0;
      any_written = 0;
      for (int i = 0; i < RING_BYTES; i++) begin
         ring_mem[i] = '0;
         ring_written[i] = 0;
      end
      restart_name_compare();
   endfunction

   // compute the response to one accepted request and advance the shadow
   function automatic result_type queue_response(item_type it);
      result_type r;
      int idx, n;
      r = '0;
      if (it.op != OP_CHECK) restart_name_compare();
      case (it.op)
         OP_PUSH: begin
            if (ring_fill + pend_len < RING_BYTES) begin
               idx = (wr_pos + pend_len) % RING_BYTES;
               ring_mem[idx] = it.data;
               ring_written[idx] = 1;
               any_written = 1;
               pend_len++;
            end else begin
               pend_ovf = 1;
            end
            if (!it.last) begin
               r.status = ST_PENDING;
            end else begin
               if (pend_ovf || desc_count >= QUEUE_DEPTH) begin
                  r.status = ST_POOL_ERR;
               end else begin
                  r.start = wr_pos[7:0];
                  r.length = pend_len[8:0];
                  desc_start[desc_tail] = wr_pos;
                  desc_len[desc_tail] = pend_len;
                  desc_prefix[desc_tail] = it.name_len;
                  wr_pos = (wr_pos + pend_len) % RING_BYTES;
                  ring_fill += pend_len;
                  desc_tail = (desc_tail + 1) % QUEUE_DEPTH;
                  desc_count++;
               end
               pend_len = 0;
               pend_ovf = 0;
            end
         end
         OP_POP: begin
            if (desc_count == 0) begin
               r.status = ST_POOL_ERR;
            end else begin
               r.start = desc_start[desc_head][7:0];
               r.length = desc_len[desc_head][8:0];
               r.prefix = desc_prefix[desc_head][7:0];
               n = (desc_len[desc_head] > ring_fill) ? ring_fill : desc_len[desc_head];
               rd_pos = (rd_pos + n) % RING_BYTES;
               ring_fill -= n;
               desc_head = (desc_head + 1) % QUEUE_DEPTH;
               desc_count--;
            end
         end
         OP_FLUSH: begin
            wr_pos = 0; rd_pos = 0; ring_fill = 0; pend_len = 0; pend_ovf = 0;
            desc_head = 0; desc_tail = 0; desc_count = 0;
         end
         OP_CHECK: begin
            if (name_pos < NAME_MAX_BYTES) begin
               idx = desc_head;
               for (int k = 0; k < desc_count; k++) begin
                  if (name_pos >= desc_prefix[idx] || name_pos >= desc_len[idx] ||
                      ring_mem[(desc_start[idx] + name_pos) % RING_BYTES] != it.data)
                     name_alive[idx] = 1'b0;
                  idx = (idx + 1) % QUEUE_DEPTH;
               end
               name_pos++;
            end
            if (!it.last) begin
               r.status = ST_PENDING;
            end else begin
               idx = desc_head;
               for (int k = 0; k < desc_count; k++) begin
                  if (name_alive[idx] && desc_prefix[idx] > 0 && desc_prefix[idx] == name_pos)
                     r.match = 1'b1;
                  idx = (idx + 1) % QUEUE_DEPTH;
               end
               restart_name_compare();
            end
         end
         OP_READ: r.rdata = ring_mem[it.offset];
         default: ;
      endcase
      r.count = desc_count[COUNT_W-1:0];
      r.empty = (desc_count == 0);
      r.full = (desc_count >= QUEUE_DEPTH);
      return r;
   endfunction

   // one request transfer, then an optional sender gap
   task automatic send_item(logic [2:0] op, logic [7:0] data, logic last,
                            logic [7:0] nlen, logic [7:0] offs);
      item_type it;
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_data_byte   <= data;
      req_last_byte   <= last;
      req_name_length <= nlen;
      req_read_offset <= offs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      it = '{op: op, data: data, last: last, name_len: nlen, offset: offs};
      expected_rsp.push_back(queue_response(it));
      sent_count++;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic push_command(int len, int prefix);
      for (int i = 0; i < len; i++)
         send_item(OP_PUSH, rand_byte(), i == len - 1, prefix[7:0], rand_byte());
   endtask

   // stream a name copied from a queued command, cut or padded to n bytes
   task automatic check_queued_name(int slot, int n);
      int idx;
      logic [7:0] b;
      idx = (desc_head + slot) % QUEUE_DEPTH;
      for (int p = 0; p < n; p++) begin
         b = (p < desc_len[idx]) ? ring_mem[(desc_start[idx] + p) % RING_BYTES]
                                 : rand_byte();
         send_item(OP_CHECK, b, p == n - 1, rand_byte(), rand_byte());
      end
   endtask

   task automatic check_random_name(int n);
      for (int p = 0; p < n; p++)
         send_item(OP_CHECK, rand_byte(), p == n - 1, rand_byte(), rand_byte());
   endtask

   // only ever read ring bytes that were written at least once
   task automatic read_written_byte();
      int offs;
      if (!any_written) begin
         send_item(OP_NOP, rand_byte(), rand_bit(), rand_byte(), rand_byte());
      end else begin
         offs = $urandom_range(RING_BYTES - 1);
         while (!ring_written[offs]) offs = (offs + 1) % RING_BYTES;
         send_item(OP_READ, rand_byte(), rand_bit(), rand_byte(), offs[7:0]);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (expected_rsp.size() == 0) begin
            $error("response transfer with nothing expected");
            fail_count++;
         end else begin
            e = expected_rsp.pop_front();
            if (e.match) match_count++;
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               fail_count++;
            end
            if (rsp_match !== e.match) begin
               $error("match: expected %0d, got %0d", e.match, rsp_match);
               fail_count++;
            end
            if (rsp_cmd_base !== e.start) begin
               $error("cmd_base: expected %0d, got %0d", e.start, rsp_cmd_base);
               fail_count++;
            end
            if (rsp_cmd_length !== e.length) begin
               $error("cmd_length: expected %0d, got %0d", e.length, rsp_cmd_length);
               fail_count++;
            end
            if (rsp_prefix_length !== e.prefix) begin
               $error("prefix_length: expected %0d, got %0d", e.prefix, rsp_prefix_length);
               fail_count++;
            end
            if (rsp_read_data !== e.rdata) begin
               $error("read_data: expected %0d, got %0d", e.rdata, rsp_read_data);
               fail_count++;
            end
            if (rsp_entry_count !== e.count) begin
               $error("entry_count: expected %0d, got %0d", e.count, rsp_entry_count);
               fail_count++;
            end
            if (rsp_is_empty !== e.empty) begin
               $error("is_empty: expected %0d, got %0d", e.empty, rsp_is_empty);
               fail_count++;
            end
            if (rsp_is_full !== e.full) begin
               $error("is_full: expected %0d, got %0d", e.full, rsp_is_full);
               fail_count++;
            end
         end
      end
   end

   // receiver backpressure
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);

   // directed cases: field extremes, each operation, corner behavior
   task automatic test_directed();
      send_item(OP_POP, 8'h00, 1'b0, 8'h00, 8'h00);   // pop while empty
      push_command(3, 2);
      push_command(1, 0);                               // zero prefix
      push_command(2, 255);                             // prefix longer than command
      check_queued_name(0, 2);                          // hits first command
      check_queued_name(1, 1);                          // zero prefix never matches
      check_queued_name(0, 1);                          // too short
      send_item(OP_READ, 8'hff, 1'b1, 8'hff, 8'h00);
      send_item(OP_READ, 8'h00, 1'b0, 8'h00, 8'h05);
      send_item(OP_PUSH, 8'hff, 1'b0, 8'h00, 8'h00);   // pending push across pop
      send_item(OP_POP, 8'hff, 1'b1, 8'hff, 8'hff);
      send_item(OP_PUSH, 8'h00, 1'b1, 8'h01, 8'h00);
      send_item(OP_CHECK, 8'h00, 1'b0, 8'h00, 8'h00);
      send_item(OP_NOP, 8'hff, 1'b1, 8'hff, 8'hff);     // unused codes restart a check
      send_item(OP_SPARE_6, 8'h00, 1'b0, 8'h00, 8'h00);
      send_item(OP_SPARE_7, 8'h55, 1'b1, 8'haa, 8'h7f);
      send_item(OP_FLUSH, 8'h00, 1'b0, 8'h00, 8'h00);
      send_item(OP_POP, 8'h00, 1'b0, 8'h00, 8'h00);
   endtask

   // random traffic, mostly well-formed pushes, pops and name checks
   task automatic test_random(int n_items);
      int stop_at, sel, len;
      stop_at = sent_count + n_items;
      while (sent_count < stop_at) begin
         sel = $urandom_range(99);
         if (sel < 35) begin
            if ($urandom_range(29) == 0) len = $urandom_range(200, 300);   // ring overflow
            else len = $urandom_range(1, 12);
            case ($urandom_range(9))
               0:       push_command(len, 0);
               1:       push_command(len, $urandom_range(len + 1, 255));
               default: push_command(len, $urandom_range(1, len < 255 ? len : 255));
            endcase
         end else if (sel < 50) begin
            send_item(OP_POP, rand_byte(), rand_bit(), rand_byte(), rand_byte());
         end else if (sel < 72) begin
            if (desc_count > 0) begin
               len = $urandom_range(desc_count - 1);
               case ($urandom_range(3))
                  0:       check_queued_name(len, $urandom_range(1, 12));
                  default: check_queued_name(len,
                              desc_prefix[(desc_head + len) % QUEUE_DEPTH] == 0 ? 1 :
                              desc_prefix[(desc_head + len) % QUEUE_DEPTH] > 12 ? 12 :
                              desc_prefix[(desc_head + len) % QUEUE_DEPTH]);
               endcase
            end else begin
               check_random_name($urandom_range(1, 3));
            end
         end else if (sel < 80) begin
            // broken check: name cut short by another operation
            send_item(OP_CHECK, rand_byte(), 1'b0, rand_byte(), rand_byte());
         end else if (sel < 90) begin
            read_written_byte();
         end else if (sel < 93) begin
            send_item(OP_FLUSH, rand_byte(), rand_bit(), rand_byte(), rand_byte());
         end else if (sel < 95) begin
            send_item(3'($urandom_range(OP_NOP, OP_SPARE_7)), rand_byte(), rand_bit(),
                      rand_byte(), rand_byte());
         end else if (sel < 96 && $urandom_range(3) == 0) begin
            check_random_name($urandom_range(256, 262));                   // long name
         end else begin
            // stray push byte left pending
            send_item(OP_PUSH, rand_byte(), 1'b0, rand_byte(), rand_byte());
         end
      end
   endtask

   initial begin
      fail_count = 0; sent_count = 0; rsp_count = 0; match_count = 0;
      tx_idle_pct = 0; rx_idle_pct = 0;
      clear_shadow();
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_operation   <= '0;
      req_data_byte   <= '0;
      req_last_byte   <= 1'b0;
      req_name_length <= '0;
      req_read_offset <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // long commands and names overshoot each phase, so the base counts stay low
      tx_idle_pct = 17; rx_idle_pct = 86;
      test_directed();
      test_random(150);
      tx_idle_pct = 86; rx_idle_pct = 17;
      test_random(150);
      tx_idle_pct = 0; rx_idle_pct = 0;
      test_random(150);

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d request transfers and %0d response transfers", sent_count,
               rsp_count);
      $display("name checks that matched: %0d", match_count);
      if (fail_count == 0 && expected_rsp.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/cpq_pkg.sv
hw/rtl/cpq_front.sv
hw/rtl/cpq_exec.sv
hw/rtl/command_packet_queue.sv
sim/tb_command_packet_queue.sv
